// ----- hw/rtl/glzw_pkg.sv -----
// Shared types and constants for the GIF LZW code stream encoder.
// Defines the code group handed from the dictionary engine to the bit packer.
// No dependencies.
package glzw_pkg;

  localparam int CODE_W     = 12;  // widest LZW code the GIF format allows
  localparam int CWID_W     = 4;   // holds a code width of up to CODE_W bits
  localparam int CFG_W      = 4;   // width of the min_code_size register
  localparam int PIX_W      = 8;   // palette index width
  localparam int BYTE_W     = 8;
  localparam int CLR_W      = 9;   // holds the clear code plus two at the largest root size
  localparam int EPOCH_W    = 8;

  // One item yields at most four codes: prefix, clear, prefix, end.
  localparam int SLOTS      = 4;
  localparam int SLOT_SEL_W = 2;
  localparam int SLOT_IDX_W = 3;   // counts 0..SLOTS

  // Packer accumulator: seven leftover bits plus every code of one item.
  localparam int ACC_W      = (BYTE_W - 1) + SLOTS * CODE_W;
  localparam int CNT_W      = 6;

  localparam int                 MCS_RESET = 8;
  localparam logic [CFG_W-1:0]   MCS_MIN   = 4'd2;
  localparam logic [CFG_W-1:0]   MCS_MAX   = 4'd8;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [CWID_W-1:0] width;
  } code_slot_t;

  typedef struct packed {
    logic                  drop;   // discard leftover bits before the first code
    logic                  flush;  // pad and send the partial byte after the last code
    logic [SLOT_IDX_W-1:0] count;  // number of valid slots, slot 0 first
    code_slot_t [SLOTS-1:0] slot;
  } code_group_t;

endpackage

// ----- hw/rtl/glzw_pack.sv -----
// Bit packer: queues code groups, packs codes LSB first and sends bytes.
// Depends on glzw_pkg for the code group type and accumulator sizes.
module glzw_pack (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 grp_valid,
  input  glzw_pkg::code_group_t grp,
  output logic                 grp_space,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 last_of_item,
  output logic                 end_of_stream
);
  import glzw_pkg::*;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;

  code_group_t            fifo [FIFO_DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [PTR_W:0]         fill;

  code_group_t            head;
  code_slot_t             cur_slot;
  logic [SLOT_IDX_W-1:0]  idx;
  logic [SLOT_IDX_W-1:0]  idx_next;
  logic [ACC_W-1:0]       acc;
  logic [ACC_W-1:0]       acc_next;
  logic [CNT_W-1:0]       cnt;
  logic [CNT_W-1:0]       cnt_next;
  logic [ACC_W-1:0]       base_acc;
  logic [CNT_W-1:0]       base_cnt;
  logic [CODE_W-1:0]      code_mask;
  logic                   can_out;
  logic                   pop;
  logic                   emit;
  logic                   emit_last;

  assign head      = fifo[rd_ptr];
  assign cur_slot  = head.slot[idx[SLOT_SEL_W-1:0]];
  assign grp_space = (fill != (PTR_W+1)'(FIFO_DEPTH));
  assign can_out   = !out_valid || out_ready;

  // Head group codes are absorbed first, one per cycle; bytes then drain one
  // per cycle unless stalled, so each group's final byte is known when sent.
  always_comb begin
    idx_next  = idx;
    acc_next  = acc;
    cnt_next  = cnt;
    pop       = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b0;
    base_acc  = (idx == '0 && head.drop) ? '0 : acc;
    base_cnt  = (idx == '0 && head.drop) ? '0 : cnt;
    code_mask = CODE_W'(((CODE_W+1)'(1) << cur_slot.width) - (CODE_W+1)'(1));
    if (fill != '0) begin
      if (idx < head.count) begin
        acc_next = base_acc | (ACC_W'(cur_slot.code & code_mask) << base_cnt);
        cnt_next = base_cnt + CNT_W'(cur_slot.width);
        idx_next = idx + SLOT_IDX_W'(1);
        if (idx_next == head.count && cnt_next < CNT_W'(BYTE_W) &&
            !(head.flush && cnt_next != '0)) begin
          pop = 1'b1;
        end
      end else if (cnt >= CNT_W'(BYTE_W)) begin
        if (can_out) begin
          emit      = 1'b1;
          emit_last = (cnt < CNT_W'(2 * BYTE_W)) && (!head.flush || cnt == CNT_W'(BYTE_W));
          acc_next  = acc >> BYTE_W;
          cnt_next  = cnt - CNT_W'(BYTE_W);
          pop       = emit_last;
        end
      end else if (head.flush && cnt != '0) begin
        if (can_out) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          acc_next  = '0;
          cnt_next  = '0;
          pop       = 1'b1;
        end
      end else begin
        pop = 1'b1;
      end
    end
    if (pop) begin
      idx_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
      idx    <= '0;
      acc    <= '0;
      cnt    <= '0;
    end else begin
      if (grp_valid) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fill <= fill + (PTR_W+1)'(grp_valid) - (PTR_W+1)'(pop);
      idx  <= idx_next;
      acc  <= acc_next;
      cnt  <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_valid) begin
      fifo[wr_ptr] <= grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte      <= acc[BYTE_W-1:0];
      last_of_item  <= emit_last;
      end_of_stream <= emit_last && head.flush;
    end
  end

endmodule

// ----- hw/rtl/gif_lzw_code_stream_encoder_top.sv -----
// GIF LZW code stream encoder, top level: dictionary engine, hash table memory, packer.
// A first-of-frame item's codes go to the packer as it is taken; any other item is read from
// the table, compared in the probe state (one more read per extra hash probe), then sent.
// No new item is taken until the engine is idle again, set by the read-then-compare/write
// turn on the single table port; bytes leave at up to 1 per cycle while out_ready allows.
// Reset: synchronous; a sweep over all 2^(MAX_CODE_BITS+1) slots clears the table first.
module gif_lzw_code_stream_encoder_top #(
  parameter int MAX_CODE_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [glzw_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                pixel_index,
  input  logic                      first_of_frame,
  input  logic                      last_of_frame,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_byte,
  output logic                      last_of_item,
  output logic                      end_of_stream
);
  import glzw_pkg::*;

  // The dictionary lives in an open-addressed hash table with linear probing.
  // Each entry holds an epoch mark, the key (prefix code, suffix index) and the
  // code assigned to it. An entry counts as present only when its epoch equals
  // the current epoch, so a dictionary restart is a single increment. When the
  // epoch counter would wrap, the table is swept back to epoch zero first.
  // The table has twice as many slots as there are codes, so a probe always
  // ends at a free slot, and a missed key is inserted exactly where its probe
  // ended. Duplicates of one key (possible when the root size changes within a
  // frame) therefore sit in code order along the probe, and the first one whose
  // code lies at or above the first free root code is the one the encoder wants.
  localparam int CW        = MAX_CODE_BITS;
  localparam int NFC_W     = CW + 1;
  localparam int HASH_W    = CW + 1;
  localparam int TBL_DEPTH = 1 << HASH_W;
  localparam int KEY_W     = CW + PIX_W;
  localparam int ENT_W     = EPOCH_W + KEY_W + CW;

  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_PROBE = 2'd2;

  // Configuration register and the derived root code values.
  logic [CFG_W-1:0]  mcs;
  logic [CFG_W-1:0]  mcs_eff;
  logic [CWID_W-1:0] root_width;
  logic [CLR_W-1:0]  clear_code;
  logic [CLR_W-1:0]  end_code;
  logic [CLR_W-1:0]  first_code;
  logic [PIX_W-1:0]  pix_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      mcs <= CFG_W'(MCS_RESET);
    end else if (cfg_we) begin
      mcs <= cfg_wdata;
    end
  end

  always_comb begin
    if (mcs < MCS_MIN) begin
      mcs_eff = MCS_MIN;
    end else if (mcs > MCS_MAX) begin
      mcs_eff = MCS_MAX;
    end else begin
      mcs_eff = mcs;
    end
  end

  assign root_width = CWID_W'(mcs_eff) + CWID_W'(1);
  assign clear_code = CLR_W'(1) << mcs_eff;
  assign end_code   = clear_code + CLR_W'(1);
  assign first_code = clear_code + CLR_W'(2);
  assign pix_mask   = PIX_W'(clear_code - CLR_W'(1));

  // Input register: the next transaction is taken while the engine works on
  // the current one.
  logic             hold_valid;
  logic [PIX_W-1:0] hold_pix;
  logic             hold_first;
  logic             hold_last;
  logic             take;
  logic             grp_space;

  assign in_ready = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_pix   <= pixel_index;
      hold_first <= first_of_frame;
      hold_last  <= last_of_frame;
    end
  end

  // Hash table memory: one port, registered read.
  logic [ENT_W-1:0]  tbl_mem [TBL_DEPTH];
  logic [ENT_W-1:0]  rd_data;
  logic [HASH_W-1:0] mem_addr;
  logic [ENT_W-1:0]  mem_wdata;
  logic              mem_we;
  logic              mem_re;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= tbl_mem[mem_addr];
    end
  end

  // Engine state.
  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [HASH_W-1:0]  probe_addr;
  logic [HASH_W-1:0]  probe_addr_next;
  logic [EPOCH_W-1:0] epoch;
  logic [EPOCH_W-1:0] epoch_next;
  logic [CW-1:0]      prefix;
  logic [CW-1:0]      prefix_next;
  logic [CWID_W-1:0]  cwid;
  logic [CWID_W-1:0]  cwid_next;
  logic [NFC_W-1:0]   nfc;
  logic [NFC_W-1:0]   nfc_next;
  logic [KEY_W-1:0]   work_key;
  logic               work_last;

  logic [PIX_W-1:0]   hold_pix_m;
  logic [KEY_W-1:0]   idle_key;
  logic [HASH_W-1:0]  idle_hash;
  logic [EPOCH_W-1:0] rd_epoch;
  logic [KEY_W-1:0]   rd_key;
  logic [CW-1:0]      rd_code;
  logic [PIX_W-1:0]   work_pix;
  logic               occupied;
  logic               hit;
  logic               restart;
  logic [CWID_W-1:0]  cw_after;
  logic [SLOT_IDX_W-1:0] n_codes;
  code_group_t        grp;
  logic               grp_valid;

  assign hold_pix_m = hold_pix & pix_mask;
  assign idle_key   = {prefix, hold_pix_m};
  assign idle_hash  = HASH_W'(prefix) ^ (HASH_W'(hold_pix_m) << (HASH_W - PIX_W)) ^
                      HASH_W'(hold_pix_m);

  assign rd_epoch = rd_data[ENT_W-1 -: EPOCH_W];
  assign rd_key   = rd_data[CW +: KEY_W];
  assign rd_code  = rd_data[CW-1:0];
  assign work_pix = work_key[PIX_W-1:0];
  assign occupied = (rd_epoch == epoch);
  assign hit      = occupied && (rd_key == work_key) &&
                    (NFC_W'(rd_code) >= NFC_W'(first_code));

  assign take = (state == ST_IDLE) && hold_valid && grp_space;

  always_comb begin
    state_next      = state;
    probe_addr_next = probe_addr;
    epoch_next      = epoch;
    prefix_next     = prefix;
    cwid_next       = cwid;
    nfc_next        = nfc;
    mem_addr        = probe_addr;
    mem_wdata       = '0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    restart         = 1'b0;
    cw_after        = cwid;
    n_codes         = '0;
    grp             = '0;
    grp_valid       = 1'b0;

    case (state)
      ST_SWEEP: begin
        // Mark every slot with epoch zero, which is never a live epoch.
        mem_we          = 1'b1;
        probe_addr_next = probe_addr + HASH_W'(1);
        if (probe_addr == '1) begin
          state_next = ST_IDLE;
          epoch_next = EPOCH_W'(1);
        end
      end

      ST_IDLE: begin
        if (take) begin
          if (hold_first) begin
            // Frame start: fresh dictionary, leftover bits dropped, clear code sent.
            restart          = 1'b1;
            prefix_next      = CW'(hold_pix_m);
            grp.drop         = 1'b1;
            grp.flush        = hold_last;
            grp.slot[0]      = '{code: CODE_W'(clear_code), width: root_width};
            grp.slot[1]      = '{code: CODE_W'(hold_pix_m), width: root_width};
            grp.slot[2]      = '{code: CODE_W'(end_code), width: root_width};
            grp.count        = hold_last ? SLOT_IDX_W'(3) : SLOT_IDX_W'(1);
            grp_valid        = 1'b1;
          end else begin
            mem_addr        = idle_hash;
            mem_re          = 1'b1;
            probe_addr_next = idle_hash;
            state_next      = ST_PROBE;
          end
        end
      end

      ST_PROBE: begin
        if (occupied && !hit) begin
          // Collision or stale duplicate: try the next slot.
          mem_addr        = probe_addr + HASH_W'(1);
          mem_re          = 1'b1;
          probe_addr_next = probe_addr + HASH_W'(1);
        end else if (hit) begin
          prefix_next = rd_code;
          state_next  = ST_IDLE;
          if (work_last) begin
            grp.flush   = 1'b1;
            grp.slot[0] = '{code: CODE_W'(rd_code), width: cwid};
            grp.slot[1] = '{code: CODE_W'(end_code), width: cwid};
            grp.count   = SLOT_IDX_W'(2);
            grp_valid   = 1'b1;
          end
        end else begin
          // Miss: send the prefix, then add the new string or restart when full.
          state_next  = ST_IDLE;
          prefix_next = CW'(work_pix);
          grp.slot[0] = '{code: CODE_W'(prefix), width: cwid};
          n_codes     = SLOT_IDX_W'(1);
          if (!nfc[CW]) begin
            mem_we    = 1'b1;
            mem_wdata = {epoch, work_key, nfc[CW-1:0]};
            if (cwid < CWID_W'(CW) && nfc == (NFC_W'(1) << cwid)) begin
              cw_after = cwid + CWID_W'(1);
            end
            cwid_next = cw_after;
            nfc_next  = nfc + NFC_W'(1);
          end else begin
            grp.slot[1] = '{code: CODE_W'(clear_code), width: cwid};
            n_codes     = SLOT_IDX_W'(2);
            restart     = 1'b1;
            cw_after    = root_width;
          end
          if (work_last) begin
            grp.flush = 1'b1;
            grp.slot[n_codes[SLOT_SEL_W-1:0]] =
              '{code: CODE_W'(work_pix), width: cw_after};
            grp.slot[n_codes[SLOT_SEL_W-1:0] + SLOT_SEL_W'(1)] =
              '{code: CODE_W'(end_code), width: cw_after};
            n_codes   = n_codes + SLOT_IDX_W'(2);
          end
          grp.count = n_codes;
          grp_valid = 1'b1;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // A restart resets width and next code and opens a new epoch; if the epoch
    // counter is exhausted the table is swept before the next lookup.
    if (restart) begin
      cwid_next = root_width;
      nfc_next  = NFC_W'(first_code);
      if (epoch == '1) begin
        state_next      = ST_SWEEP;
        probe_addr_next = '0;
      end else begin
        epoch_next = epoch + EPOCH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      probe_addr <= '0;
      epoch      <= EPOCH_W'(1);
      prefix     <= '0;
      cwid       <= CWID_W'(MCS_RESET + 1);
      nfc        <= NFC_W'((1 << MCS_RESET) + 2);
    end else begin
      state      <= state_next;
      probe_addr <= probe_addr_next;
      epoch      <= epoch_next;
      prefix     <= prefix_next;
      cwid       <= cwid_next;
      nfc        <= nfc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      work_key  <= idle_key;
      work_last <= hold_last;
    end
  end

  // Byte packing and the output register.
  glzw_pack u_pack (
    .clk           (clk),
    .rst           (rst),
    .grp_valid     (grp_valid),
    .grp           (grp),
    .grp_space     (grp_space),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .last_of_item  (last_of_item),
    .end_of_stream (end_of_stream)
  );

  // The single table port never reads and writes in the same cycle.
  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("table read and write in the same cycle");

  // Every compare works on data read in the previous cycle.
  a_probe_has_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |-> $past(mem_re))
    else $error("probe without a preceding table read");

  // A live entry always carries a code below the next free code.
  a_hit_code_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE && hit) |-> (NFC_W'(rd_code) < nfc))
    else $error("dictionary hit on a code not yet assigned");

  // The frame's final byte is also the final byte of its transaction.
  a_eos_ends_item: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_stream) |-> last_of_item)
    else $error("end of stream without end of item");

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for gif_lzw_code_stream_encoder_top.
// Holds its own LZW encoder and bit packer that predict every output byte.
// Depends on glzw_pkg and the encoder RTL only.
module tb;
  import glzw_pkg::*;

  // The widest code of the format and the dictionary size that follows from it.
  localparam int MAX_BITS       = 12;
  localparam int TABLE_DEPTH    = 1 << MAX_BITS;
  // Cycles allowed for an item that yields no byte to leave the pipeline before
  // a register write, and for stray bytes to show up at the end of the run.
  localparam int DRAIN_CYCLES   = 128;
  // The reset sweep over all 2^13 hash table slots is the longest quiet stretch of a
  // good run; the watchdog allows several times that.
  localparam int WATCHDOG_LIMIT = 30000;
  localparam int REPORT_LIMIT   = 10;

  // One byte of code stream together with its framing flags.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              item_end;
    logic              stream_end;
  } stream_byte_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [PIX_W-1:0]  pixel_index = '0;
  logic              first_of_frame = 1'b0;
  logic              last_of_frame = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_item;
  logic              end_of_stream;

  gif_lzw_code_stream_encoder_top #(
    .MAX_CODE_BITS(MAX_BITS)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pixel_index   (pixel_index),
    .first_of_frame(first_of_frame),
    .last_of_frame (last_of_frame),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .last_of_item  (last_of_item),
    .end_of_stream (end_of_stream)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Encoder prediction.
  // The testbench keeps its own copy of the dictionary, the code width, the next
  // free code, the current prefix and the bits left over from the last byte.
  // Every accepted input transaction is run through it, and the bytes that it
  // yields are queued in expected_bytes in the order the block must send them.
  // ---------------------------------------------------------------------------
  stream_byte_t      expected_bytes[$];
  stream_byte_t      item_bytes[$];

  logic [CFG_W-1:0]  root_size_reg;
  logic [19:0]       dict_key[TABLE_DEPTH];
  bit                dict_used[TABLE_DEPTH];
  int unsigned       prefix_code;
  int unsigned       code_bits;
  int unsigned       free_code;
  logic [6:0]        carry_bits;
  int unsigned       carry_count;
  logic [63:0]       bit_acc;
  int unsigned       bit_count;

  // Out-of-range register values are clamped to the legal root sizes.
  function automatic int unsigned root_bits();
    if (root_size_reg < MCS_MIN) return MCS_MIN;
    if (root_size_reg > MCS_MAX) return MCS_MAX;
    return root_size_reg;
  endfunction

  function automatic void restart_dictionary();
    foreach (dict_used[i]) dict_used[i] = 1'b0;
    code_bits = root_bits() + 1;
    free_code = (1 << root_bits()) + 2;
  endfunction

  function automatic void reset_encoder_model();
    root_size_reg = MCS_RESET;
    restart_dictionary();
    prefix_code = 0;
    carry_bits = '0;
    carry_count = 0;
  endfunction

  // Appends one code LSB first and moves out every byte that is complete.
  function automatic void pack_code(int unsigned code, int unsigned width);
    bit_acc = bit_acc | ((64'(code) & ((64'd1 << width) - 64'd1)) << bit_count);
    bit_count = bit_count + width;
    while (bit_count >= 8) begin
      item_bytes.push_back({bit_acc[7:0], 2'b00});
      bit_acc = bit_acc >> 8;
      bit_count = bit_count - 8;
    end
  endfunction

  function automatic void encode_pixel(logic [PIX_W-1:0] pix_in, logic first, logic last);
    int unsigned clear_code;
    int unsigned pix;
    int unsigned c;
    logic [19:0] key;
    bit hit;
    stream_byte_t tail;

    clear_code = 1 << root_bits();
    pix = pix_in & (clear_code - 1);
    item_bytes.delete();
    bit_acc = 64'(carry_bits);
    bit_count = carry_count;

    if (first) begin
      // A new frame drops whatever an unfinished frame left behind.
      bit_acc = '0;
      bit_count = 0;
      restart_dictionary();
      pack_code(clear_code, code_bits);
      prefix_code = pix;
    end else begin
      key = {prefix_code[11:0], pix[7:0]};
      hit = 1'b0;
      for (c = clear_code + 2; c < free_code && c < TABLE_DEPTH; c++) begin
        if (dict_used[c] && dict_key[c] == key) begin
          hit = 1'b1;
          break;
        end
      end
      if (hit) begin
        prefix_code = c & 12'hFFF;
      end else begin
        pack_code(prefix_code, code_bits);
        if (free_code < TABLE_DEPTH) begin
          dict_key[free_code] = key;
          dict_used[free_code] = 1'b1;
          if (code_bits < MAX_BITS && free_code == (1 << code_bits)) code_bits++;
          free_code++;
        end else begin
          // Table is full: tell the decoder to start over.
          pack_code(clear_code, code_bits);
          restart_dictionary();
        end
        prefix_code = pix;
      end
    end

    if (last) begin
      pack_code(prefix_code, code_bits);
      pack_code(clear_code + 1, code_bits);
      if (bit_count > 0) begin
        item_bytes.push_back({bit_acc[7:0], 2'b00});
        bit_acc = '0;
        bit_count = 0;
      end
      if (item_bytes.size() > 0) begin
        tail = item_bytes[item_bytes.size() - 1];
        tail.stream_end = 1'b1;
        item_bytes[item_bytes.size() - 1] = tail;
      end
    end
    if (item_bytes.size() > 0) begin
      tail = item_bytes[item_bytes.size() - 1];
      tail.item_end = 1'b1;
      item_bytes[item_bytes.size() - 1] = tail;
    end

    carry_bits = bit_acc[6:0];
    carry_count = bit_count & 7;
    foreach (item_bytes[i]) expected_bytes.push_back(item_bytes[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Failure bookkeeping. Only the first ten failures are printed; the rest are counted.
  // ---------------------------------------------------------------------------
  int unsigned error_count = 0;

  function automatic void report_failure(string what);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("%s", what);
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: a random ready pattern and a check of each byte transaction
  // against the oldest expected byte. Stalls come in bursts and are switched off
  // for the last part of the run.
  // ---------------------------------------------------------------------------
  bit output_stalls = 1'b1;
  int unsigned stall_left = 0;

  always @(posedge clk) begin : byte_checker
    stream_byte_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          report_failure($sformatf("unexpected byte %02h item_end %0b stream_end %0b",
                                   out_byte, last_of_item, end_of_stream));
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data || last_of_item !== want.item_end ||
              end_of_stream !== want.stream_end) begin
            report_failure($sformatf(
              "byte mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
              want.data, want.item_end, want.stream_end,
              out_byte, last_of_item, end_of_stream));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (output_stalls && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a run that stops moving transactions in either direction for too
  // long has hung, most likely on a missing byte.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side.
  // send_pixel leaves in_valid high after its transaction is accepted, so that a
  // following call can present the next pixel in the same time step without a
  // second assignment. Whoever stops sending calls finish_phase, which lowers it.
  // ---------------------------------------------------------------------------
  bit input_gaps = 1'b1;

  task automatic send_pixel(logic [PIX_W-1:0] pix, logic first, logic last);
    if (input_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    pixel_index    <= pix;
    first_of_frame <= first;
    last_of_frame  <= last;
    do @(posedge clk); while (!in_ready);
    encode_pixel(pix, first, last);
  endtask

  // Stops the input, waits for every expected byte, then lets the pipeline go
  // quiet, since items that end on a dictionary hit leave no byte behind.
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Only ever called right after finish_phase, so the block is idle.
  task automatic write_root_size(logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    root_size_reg = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // A pixel from a small alphabet makes dictionary hits likely; the bits above
  // the root size are random, since the block must ignore them.
  function automatic logic [PIX_W-1:0] random_pixel(int unsigned alphabet);
    logic [PIX_W-1:0] low_mask;
    logic [PIX_W-1:0] noise;
    logic [PIX_W-1:0] symbol;
    low_mask = PIX_W'((1 << root_bits()) - 1);
    noise    = PIX_W'($urandom);
    symbol   = PIX_W'($urandom_range(0, alphabet - 1));
    return (noise & ~low_mask) | (symbol & low_mask);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Right after reset no frame has begun: the prefix is zero and the items are
  // encoded against the reset state, root size 8.
  task automatic test_no_frame_after_reset();
    send_pixel(8'd5, 1'b0, 1'b0);
    send_pixel(8'd5, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b1);
    finish_phase();
  endtask

  // A frame of one pixel sends clear, the pixel and end in a single item,
  // at the largest and at the smallest root size.
  task automatic test_single_pixel_frame();
    write_root_size(MCS_MAX);
    send_pixel(8'd255, 1'b1, 1'b1);
    finish_phase();
    write_root_size(MCS_MIN);
    send_pixel(8'd255, 1'b1, 1'b1);
    finish_phase();
  endtask

  // Extreme pixel values, runs that hit the dictionary, and masked high bits.
  task automatic test_pixel_extremes();
    write_root_size(MCS_MAX);
    send_pixel(8'd0, 1'b1, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b0);
    send_pixel(8'd0, 1'b0, 1'b1);
    finish_phase();
    write_root_size(MCS_MIN);
    send_pixel(8'hFC, 1'b1, 1'b0);
    send_pixel(8'h03, 1'b0, 1'b0);
    send_pixel(8'hFF, 1'b0, 1'b1);
    finish_phase();
  endtask

  // Register values outside 2..8 are clamped by the block.
  task automatic test_root_size_out_of_range();
    write_root_size(4'd0);
    send_pixel(8'hFF, 1'b1, 1'b1);
    finish_phase();
    write_root_size(4'd1);
    send_pixel(8'h5A, 1'b1, 1'b1);
    finish_phase();
    write_root_size(4'd9);
    send_pixel(8'hAA, 1'b1, 1'b1);
    finish_phase();
    write_root_size(4'd15);
    send_pixel(8'h81, 1'b1, 1'b1);
    finish_phase();
  endtask

  // A frame without an end is cut off by the next start: its leftover bits are
  // dropped and the dictionary begins again.
  task automatic test_unterminated_frame();
    write_root_size(4'd5);
    send_pixel(8'd3, 1'b1, 1'b0);
    send_pixel(8'd7, 1'b0, 1'b0);
    send_pixel(8'd1, 1'b1, 1'b0);
    send_pixel(8'd2, 1'b0, 1'b1);
    finish_phase();
  endtask

  // The root size changes halfway through a frame; mask, clear and end codes
  // follow the new value at once while the dictionary carries on.
  task automatic test_root_size_change_mid_frame();
    write_root_size(MCS_MAX);
    send_pixel(8'd200, 1'b1, 1'b0);
    send_pixel(8'd201, 1'b0, 1'b0);
    finish_phase();
    write_root_size(4'd3);
    send_pixel(8'd9, 1'b0, 1'b0);
    send_pixel(8'd4, 1'b0, 1'b0);
    send_pixel(8'd5, 1'b0, 1'b1);
    finish_phase();
  endtask

  // One long frame of mostly new pixel pairs fills all 4096 codes, which walks
  // the code width up to 12 bits and forces a clear in the middle of the frame.
  // Stepping through the palette with odd strides keeps almost every pair new.
  task automatic test_dictionary_full();
    int unsigned stride;
    int unsigned i;
    write_root_size(MCS_MAX);
    for (stride = 1; stride <= 35; stride += 2) begin
      for (i = 0; i < 256; i++) begin
        send_pixel(PIX_W'(i * stride), stride == 1 && i == 0, stride == 35 && i == 255);
      end
    end
    finish_phase();
  endtask

  // Random frames of random length and alphabet. Most frames are well formed;
  // a few lose their start or end marker, or end early, so that items are also
  // encoded outside any frame. The root size changes now and then between frames.
  task automatic test_random_frames(int unsigned item_budget);
    int unsigned sent;
    int unsigned frame_len;
    int unsigned alphabet;
    int unsigned k;
    logic first;
    logic last;
    sent = 0;
    while (sent < item_budget) begin
      if ($urandom_range(0, 3) == 0) begin
        finish_phase();
        if ($urandom_range(0, 4) == 0) write_root_size(CFG_W'($urandom_range(0, 15)));
        else write_root_size(CFG_W'($urandom_range(MCS_MIN, MCS_MAX)));
      end
      frame_len = $urandom_range(1, 40);
      case ($urandom_range(0, 3))
        0: alphabet = 2;
        1: alphabet = 4;
        2: alphabet = 16;
        default: alphabet = 256;
      endcase
      for (k = 0; k < frame_len; k++) begin
        first = (k == 0);
        last  = (k == frame_len - 1);
        if ($urandom_range(0, 19) == 0) first = ~first;
        if ($urandom_range(0, 19) == 0) last = ~last;
        send_pixel(random_pixel(alphabet), first, last);
        sent++;
      end
    end
    finish_phase();
  endtask

  initial begin
    reset_encoder_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_no_frame_after_reset();
    test_single_pixel_frame();
    test_pixel_extremes();
    test_root_size_out_of_range();
    test_unterminated_frame();
    test_root_size_change_mid_frame();
    test_dictionary_full();
    test_random_frames(260);

    // The tail of the run goes at full rate on both sides.
    input_gaps = 1'b0;
    output_stalls = 1'b0;
    test_random_frames(60);

    if (error_count == 0 && expected_bytes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
